// File: rtl/core/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants for the pulse-distance infrared transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

    localparam int unsigned CfgW      = 16;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned FrameBits = 32;
    localparam int unsigned BitIdxW   = 6;

    localparam logic [CfgW-1:0] CustomCodeRst = 16'hff00;
    localparam logic [CfgW-1:0] StartLowRst   = 16'd16;
    localparam logic [CfgW-1:0] StartHighRst  = 16'd8;
    localparam logic [CfgW-1:0] ShortRst      = 16'd1;
    localparam logic [CfgW-1:0] LongRst       = 16'd3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CUSTOM_CODE = 3'd0,
        REG_START_LOW   = 3'd1,
        REG_START_HIGH  = 3'd2,
        REG_SHORT       = 3'd3,
        REG_LONG        = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_START_HIGH = 3'd2,
        PH_MARK       = 3'd3,
        PH_SPACE      = 3'd4,
        PH_FINAL      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [CfgW-1:0] custom_code;
        logic [CfgW-1:0] start_low_ticks;
        logic [CfgW-1:0] start_high_ticks;
        logic [CfgW-1:0] short_ticks;
        logic [CfgW-1:0] long_ticks;
    } cfg_t;

    // packed from the lowest bit up: ir_level, busy_res, rejected, frame_done
    typedef struct packed {
        logic frame_done;
        logic rejected;
        logic busy_res;
        logic ir_level;
    } result_t;

    // a zero length counts as one tick
    function automatic logic [CfgW-1:0] len_of(input logic [CfgW-1:0] v);
        return (v == '0) ? CfgW'(1) : v;
    endfunction

endpackage

// File: rtl/core/irpdt_engine.sv
// ----------------------------------------------------------------------------
// irpdt_engine
// Frame sequencer: phase, tick counter, bit counter and shift word, one item
// per cycle with item_valid high, the result computed from the current state.
// ----------------------------------------------------------------------------
module irpdt_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        func,
    input  logic [15:0]                 key_code,
    input  irpdt_pkg::cfg_t             cfg,
    output irpdt_pkg::result_t          res
);
    import irpdt_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BitIdxW-1:0]  bit_index_reg, bit_index_next;
    logic [FrameBits-1:0] shift_reg, shift_next;
    logic [CfgW-1:0]     tick_left_reg, tick_left_next;
    logic                pin_reg, pin_next;
    logic                busy;
    logic [CfgW-1:0]     tick_dec;
    logic [BitIdxW-1:0]  bit_inc;
    logic                rej, done;

    assign busy     = (phase_reg != PH_IDLE);
    assign tick_dec = (tick_left_reg != '0) ? tick_left_reg - CfgW'(1) : '0;
    assign bit_inc  = bit_index_reg + BitIdxW'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        tick_left_next = tick_left_reg;
        pin_next       = pin_reg;
        rej            = 1'b0;
        done           = 1'b0;
        if (func)
        begin
            if (busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                shift_next     = {key_code, cfg.custom_code};
                bit_index_next = '0;
                phase_next     = PH_START_LOW;
                tick_left_next = len_of(cfg.start_low_ticks);
                pin_next       = 1'b0;
            end
        end
        else if (!busy)
        begin
            phase_next = PH_IDLE;
            pin_next   = 1'b1;
        end
        else
        begin
            tick_left_next = tick_dec;
            if (tick_dec == '0)
            begin
                unique case (phase_reg)
                    PH_START_LOW:
                    begin
                        phase_next     = PH_START_HIGH;
                        pin_next       = 1'b1;
                        tick_left_next = len_of(cfg.start_high_ticks);
                    end
                    PH_START_HIGH:
                    begin
                        phase_next     = PH_MARK;
                        pin_next       = 1'b0;
                        tick_left_next = len_of(cfg.short_ticks);
                    end
                    PH_MARK:
                    begin
                        phase_next     = PH_SPACE;
                        pin_next       = 1'b1;
                        tick_left_next = shift_reg[0] ? len_of(cfg.long_ticks)
                                                      : len_of(cfg.short_ticks);
                    end
                    PH_SPACE:
                    begin
                        shift_next     = {1'b0, shift_reg[FrameBits-1:1]};
                        bit_index_next = bit_inc;
                        pin_next       = 1'b0;
                        tick_left_next = len_of(cfg.short_ticks);
                        phase_next     = (bit_inc >= BitIdxW'(FrameBits)) ? PH_FINAL
                                                                          : PH_MARK;
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        pin_next       = 1'b1;
                        bit_index_next = '0;
                        tick_left_next = '0;
                        done           = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.ir_level   = pin_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.rejected   = rej;
        res.frame_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            tick_left_reg <= '0;
            pin_reg       <= 1'b1;
        end
        else if (item_valid)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            tick_left_reg <= tick_left_next;
            pin_reg       <= pin_next;
        end
    end

endmodule

// File: rtl/core/ir_pulse_distance_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter
// Pulse-distance infrared frame transmitter driven by tick and send items.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser = 0 is one time tick, tuser = 1 is a
//   send command with the key code in tdata. A send while a frame is in
//   progress is dropped and flagged as rejected.
//   Every input item yields exactly one result item on m_axis, giving the pin
//   level, busy flag, rejected flag and frame-done flag after that item.
//   Results are registered in the output or, on a stall, the skid register;
//   one item per cycle is taken while s_axis_tready is high.
//   A two-entry result buffer (output register plus skid register) lets
//   s_axis_tready stay high while one result waits; it drops only when both
//   hold results the receiver has not taken.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_wdata at any edge with cfg_we high; indexes beyond the list are
//   ignored. Lengths are in ticks, zero acting as one.
//   Reset returns the sequencer to idle with the pin high, empties the
//   result buffer and loads the register reset values.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // key_code
    input  logic                          s_axis_tuser,   // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // ir_level, busy_res,
                                                          // rejected, frame_done, 4'b0
    input  logic                          cfg_we,
    input  logic [irpdt_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [irpdt_pkg::CfgW-1:0]    cfg_wdata
);
    import irpdt_pkg::*;

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept;
    logic    out_free;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = m_axis_tready || !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.custom_code      <= CustomCodeRst;
            cfg_reg.start_low_ticks  <= StartLowRst;
            cfg_reg.start_high_ticks <= StartHighRst;
            cfg_reg.short_ticks      <= ShortRst;
            cfg_reg.long_ticks       <= LongRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUSTOM_CODE: cfg_reg.custom_code      <= cfg_wdata;
                REG_START_LOW:   cfg_reg.start_low_ticks  <= cfg_wdata;
                REG_START_HIGH:  cfg_reg.start_high_ticks <= cfg_wdata;
                REG_SHORT:       cfg_reg.short_ticks      <= cfg_wdata;
                REG_LONG:        cfg_reg.long_ticks       <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    irpdt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (accept),
        .func       (s_axis_tuser),
        .key_code   (s_axis_tdata),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // hold a stalled result in the skid register, drain it first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

endmodule

// File: test/ir_pulse_distance_transmitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_tb
// Streams tick and send items into the transmitter and checks every result
// item against a cycle-free model of the frame sequencer kept in the bench.
// Register settings range from all-zero lengths to the 65535-tick maximum,
// with random gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_tb;

    import irpdt_pkg::*;

    localparam int unsigned CycleLimit = 1_500_000;

    typedef struct packed {
        logic        func;
        logic [15:0] key;
    } ir_cmd_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic                cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index     = '0;
    logic [CfgW-1:0]     cfg_wdata     = '0;

    // transmitter model state and its register copy
    cfg_t                tx_cfg;
    phase_t              tx_phase;
    logic [BitIdxW-1:0]  tx_bit;
    logic [31:0]         tx_word;
    logic [15:0]         tx_left;
    logic                tx_pin;

    ir_cmd_t             pending_cmds[$];
    result_t             due_pin_states[$];

    int unsigned         send_gap_pct  = 7;
    int unsigned         take_gap_pct  = 52;
    logic                hold_arm      = 1'b0;
    int unsigned         cmds_queued   = 0;
    int unsigned         cmds_sent     = 0;
    int unsigned         results_seen  = 0;
    int unsigned         frames_seen   = 0;
    int unsigned         refusals_seen = 0;
    int unsigned         mismatches    = 0;
    int unsigned         cycles        = 0;

    ir_pulse_distance_transmitter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] tick_span(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic result_t advance_ir_frame(input logic func, input logic [15:0] key);
        result_t r;
        r = '0;
        if (func)
        begin
            if (tx_phase != PH_IDLE)
                r.rejected = 1'b1;
            else
            begin
                tx_word  = {key, tx_cfg.custom_code};
                tx_bit   = '0;
                tx_phase = PH_START_LOW;
                tx_left  = tick_span(tx_cfg.start_low_ticks);
                tx_pin   = 1'b0;
            end
        end
        else if (tx_phase != PH_IDLE)
        begin
            if (tx_left != 16'd0)
                tx_left = tx_left - 16'd1;
            if (tx_left == 16'd0)
            begin
                case (tx_phase)
                    PH_START_LOW:
                    begin
                        tx_phase = PH_START_HIGH;
                        tx_pin   = 1'b1;
                        tx_left  = tick_span(tx_cfg.start_high_ticks);
                    end
                    PH_START_HIGH:
                    begin
                        tx_phase = PH_MARK;
                        tx_pin   = 1'b0;
                        tx_left  = tick_span(tx_cfg.short_ticks);
                    end
                    PH_MARK:
                    begin
                        tx_phase = PH_SPACE;
                        tx_pin   = 1'b1;
                        tx_left  = tx_word[0] ? tick_span(tx_cfg.long_ticks)
                                              : tick_span(tx_cfg.short_ticks);
                    end
                    PH_SPACE:
                    begin
                        tx_word  = tx_word >> 1;
                        tx_bit   = tx_bit + BitIdxW'(1);
                        tx_pin   = 1'b0;
                        tx_left  = tick_span(tx_cfg.short_ticks);
                        tx_phase = (tx_bit >= BitIdxW'(FrameBits)) ? PH_FINAL : PH_MARK;
                    end
                    default:
                    begin
                        tx_phase     = PH_IDLE;
                        tx_pin       = 1'b1;
                        tx_bit       = '0;
                        tx_left      = '0;
                        r.frame_done = 1'b1;
                    end
                endcase
            end
        end
        r.ir_level = tx_pin;
        r.busy_res = (tx_phase != PH_IDLE);
        return r;
    endfunction

    // ticks from a send to the end of the final mark
    function automatic int unsigned frame_ticks(input logic [31:0] word);
        int unsigned n;
        int unsigned mark;
        mark = tick_span(tx_cfg.short_ticks);
        n    = tick_span(tx_cfg.start_low_ticks) + tick_span(tx_cfg.start_high_ticks) + mark;
        for (int i = 0; i < 32; i++)
            n += mark + (word[i] ? tick_span(tx_cfg.long_ticks) : mark);
        return n;
    endfunction

    task automatic push_cmd(input logic func, input logic [15:0] key);
        ir_cmd_t c;
        c.func = func;
        c.key  = key;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_frame(input logic [15:0] key, input int unsigned refuse_pct);
        int unsigned n;
        n = frame_ticks({key, tx_cfg.custom_code});
        push_cmd(1'b1, key);
        repeat (n)
        begin
            if ($urandom_range(99) < refuse_pct)
                push_cmd(1'b1, 16'($urandom));
            push_cmd(1'b0, 16'($urandom));
        end
    endtask

    // random items and broken frames, then enough ticks to return to idle
    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(12, 2);
        repeat (n)
            push_cmd($urandom_range(3) == 0, 16'($urandom));
        n = frame_ticks(32'hffff_ffff) + frame_ticks(32'h0);
        repeat (n)
            push_cmd(1'b0, 16'($urandom));
    endtask

    task automatic fill_random(input int unsigned target);
        int unsigned base;
        base = cmds_queued;
        while (cmds_queued - base < target)
        begin
            if ($urandom_range(9) == 0)
                queue_noise();
            else
            begin
                queue_frame(16'($urandom), 4);
                repeat ($urandom_range(2))
                    push_cmd(1'b0, 16'($urandom));
            end
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CfgW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CUSTOM_CODE: tx_cfg.custom_code      = val;
            REG_START_LOW:   tx_cfg.start_low_ticks  = val;
            REG_START_HIGH:  tx_cfg.start_high_ticks = val;
            REG_SHORT:       tx_cfg.short_ticks      = val;
            REG_LONG:        tx_cfg.long_ticks       = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || s_axis_tvalid || due_pin_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic want, input logic got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : drive_items
        ir_cmd_t nxt;
        logic    load;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                due_pin_states.push_back(advance_ir_frame(s_axis_tuser, s_axis_tdata));
                cmds_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                load = (pending_cmds.size() != 0) && ($urandom_range(99) >= send_gap_pct);
                if (load)
                begin
                    nxt = pending_cmds.pop_front();
                    s_axis_tuser <= nxt.func;
                    s_axis_tdata <= nxt.key;
                end
                s_axis_tvalid <= load;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t     got;
        result_t     want;
        int unsigned hold_left;
        logic        hold_done;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[3:0];
                frames_seen   += got.frame_done;
                refusals_seen += got.rejected;
                if (due_pin_states.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result item, expected none, got %b",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = due_pin_states.pop_front();
                    results_seen++;
                    check_field("ir_level", want.ir_level, got.ir_level);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("rejected", want.rejected, got.rejected);
                    check_field("frame_done", want.frame_done, got.frame_done);
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("ir_pulse_distance_transmitter_tb: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        tx_cfg   = '{CustomCodeRst, StartLowRst, StartHighRst, ShortRst, LongRst};
        tx_phase = PH_IDLE;
        tx_bit   = '0;
        tx_word  = '0;
        tx_left  = '0;
        tx_pin   = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: idle ticks, a send, a refused send, a full frame
        push_cmd(1'b0, 16'h0000);
        push_cmd(1'b0, 16'hffff);
        push_cmd(1'b1, 16'hffff);
        push_cmd(1'b1, 16'h0000);
        repeat (frame_ticks({16'hffff, tx_cfg.custom_code}))
            push_cmd(1'b0, 16'h5a5a);
        push_cmd(1'b0, 16'ha5a5);
        queue_frame(16'h0000, 0);
        drain();

        // zero lengths act as one tick
        write_reg(REG_CUSTOM_CODE, 16'h0000);
        write_reg(REG_START_LOW, 16'd0);
        write_reg(REG_START_HIGH, 16'd0);
        write_reg(REG_SHORT, 16'd0);
        write_reg(REG_LONG, 16'd0);
        fill_random(120);
        drain();

        send_gap_pct = 52;
        take_gap_pct = 7;
        write_reg(REG_CUSTOM_CODE, 16'($urandom));
        write_reg(REG_START_LOW, 16'($urandom_range(3, 1)));
        write_reg(REG_START_HIGH, 16'($urandom_range(3, 1)));
        write_reg(REG_SHORT, 16'($urandom_range(3, 1)));
        write_reg(REG_LONG, 16'($urandom_range(3, 1)));
        fill_random(120);
        drain();

        // no gaps; hold the receiver off so the input stalls
        send_gap_pct = 0;
        take_gap_pct = 0;
        write_reg(REG_CUSTOM_CODE, 16'hffff);
        write_reg(REG_START_LOW, 16'd1);
        write_reg(REG_START_HIGH, 16'd2);
        write_reg(REG_SHORT, 16'd1);
        write_reg(REG_LONG, 16'd2);
        hold_arm = 1'b1;
        fill_random(120);
        drain();

        // longest one-bit space, followed partway into its countdown
        write_reg(REG_CUSTOM_CODE, 16'h0001);
        write_reg(REG_START_LOW, 16'd1);
        write_reg(REG_START_HIGH, 16'd1);
        write_reg(REG_SHORT, 16'd1);
        write_reg(REG_LONG, 16'hffff);
        push_cmd(1'b1, 16'h0001);
        push_cmd(1'b1, 16'hfffe);
        repeat (40)
            push_cmd(1'b0, 16'($urandom));
        drain();

        $display("covered %0d items and %0d checked results over five register settings",
                 cmds_sent, results_seen);
        $display("frames completed: %0d, sends refused while busy: %0d",
                 frames_seen, refusals_seen);
        if (mismatches == 0)
            $display("ir_pulse_distance_transmitter_tb: clean");
        else
            $display("ir_pulse_distance_transmitter_tb: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/irpdt_pkg.sv
rtl/core/irpdt_engine.sv
rtl/core/ir_pulse_distance_transmitter.sv
test/ir_pulse_distance_transmitter_tb.sv
